// ===== rtl/core/isort_pkg.sv =====
// Shared constants and control types for the insertion sorter.
`default_nettype none

package isort_pkg;

    // Number of values one set can hold.
    localparam int CAPACITY = 32;

    // Width of the fill count, which must hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Width of a stored value.
    localparam int VAL_W = 32;

    // Controller states.
    typedef enum logic [0:0] {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;
        logic shift_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_entry;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/core/isort_in_if.sv =====
// Input request channel of the insertion sorter.
`default_nettype none

interface isort_in_if
    import isort_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  sample_value;
    logic                     is_last;

    modport source (output valid, output sample_value, output is_last, input ready);
    modport sink   (input valid, input sample_value, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/isort_out_if.sv =====
// Output request channel of the insertion sorter.
`default_nettype none

interface isort_out_if
    import isort_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  sorted_value;
    logic                     run_last;
    logic                     dropped_any;

    modport source (output valid, output sorted_value, output run_last,
                    output dropped_any, input ready);
    modport sink   (input valid, input sorted_value, input run_last,
                    input dropped_any, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/isort_ctrl.sv =====
// Controller state machine: alternates between filling and draining a set.
`default_nettype none

module isort_ctrl
    import isort_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_last,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a last request starts the drain, the final result ends it.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (i_in_valid && i_in_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_out_ready && i_stat.last_entry) begin
                    n_state = ST_FILL;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    // Handshake outputs and datapath commands.
    always_comb begin
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        o_cmd.insert    = 1'b0;
        o_cmd.shift_out = 1'b0;
        case (r_state)
            ST_FILL: begin
                o_in_ready   = 1'b1;
                o_cmd.insert = i_in_valid;
            end
            ST_DRAIN: begin
                o_out_valid     = 1'b1;
                o_cmd.shift_out = i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/isort_dp.sv =====
// Datapath: a row of sorted cells with parallel insertion and shift-out.
`default_nettype none

module isort_dp
    import isort_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    input  wire logic signed [VAL_W-1:0] i_value,
    output t_dp_stat                     o_stat,
    output logic signed [VAL_W-1:0]      o_head,
    output logic                         o_overflow
);

    logic signed [VAL_W-1:0] r_cell [CAPACITY];
    logic signed [VAL_W-1:0] n_cell [CAPACITY];
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_overflow;
    logic                    n_overflow;
    logic [CAPACITY-1:0]     w_greater;
    logic                    w_full;

    assign w_full = (r_count == CNT_W'(CAPACITY));

    // Each valid cell compares itself against the new value.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_greater[i] = (CNT_W'(i) < r_count) && (r_cell[i] > i_value);
        end
    end

    // Next cell contents: insert opens a gap, shift-out moves every cell down.
    always_comb begin
        n_count    = r_count;
        n_overflow = r_overflow;
        for (int i = 0; i < CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
        end
        if (i_cmd.insert) begin
            if (w_full) begin
                n_overflow = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
                for (int i = 0; i < CAPACITY; i++) begin
                    // Cells above the new value and the first free cell take part.
                    if (w_greater[i] || (CNT_W'(i) == r_count)) begin
                        if ((i > 0) && w_greater[(i > 0) ? i - 1 : 0]) begin
                            n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                        end else begin
                            n_cell[i] = i_value;
                        end
                    end
                end
            end
        end else if (i_cmd.shift_out) begin
            n_count = r_count - 1'b1;
            for (int i = 0; i < CAPACITY - 1; i++) begin
                n_cell[i] = r_cell[i + 1];
            end
            // The set is finished once its final entry leaves.
            if (o_stat.last_entry) begin
                n_overflow = 1'b0;
            end
        end
    end

    // Cell row holds payload only; count and overflow flag are control state.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_overflow <= n_overflow;
        end
    end

    assign o_stat.last_entry = (r_count == CNT_W'(1));
    assign o_head            = r_cell[0];
    assign o_overflow        = r_overflow;

endmodule

`default_nettype wire

// ===== rtl/core/insertion_sorter.sv =====
// Top level of the insertion sorter: controller, datapath and channel ports.
// Fill: one request accepted per cycle; each value is inserted in the cycle it arrives.
// Drain: the first result is offered in the cycle after the last request is accepted,
// then one result per cycle while the output is ready, set by the shift of the cell row
// toward its head. A set of n values yields min(n, CAPACITY) results; no input is
// taken while draining.
// Reset clears the fill count and drop flag; cell contents are left as they are.
`default_nettype none

module insertion_sorter
    import isort_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    isort_in_if.sink     i_in,
    isort_out_if.source  o_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencing of fill and drain.
    isort_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.is_last),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    // Sorted cell row.
    isort_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_value    (i_in.sample_value),
        .o_stat     (w_stat),
        .o_head     (o_out.sorted_value),
        .o_overflow (o_out.dropped_any)
    );

    assign o_out.run_last = w_stat.last_entry;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the insertion sorter: random sets, channel stalls and overflow.
`default_nettype none

module tb
    import isort_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 140;
    localparam int LONG_HOLD = 80;
    localparam int HOLD_AFTER = 25;
    localparam int SETTLE_CYCLES = 10;
    localparam logic signed [VAL_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VMAX = 32'sh7fff_ffff;

    // How the values of one set are picked.
    typedef enum int {
        FILL_WIDE,
        FILL_NARROW,
        FILL_EDGES
    } t_fill_mode;

    // One result of a sorted set as it should appear on the output channel.
    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic                    run_last;
        logic                    dropped_any;
    } t_sorted_result;

    // Tracks the set being collected and the sorted results still owed by the block.
    class sort_scoreboard;
        logic signed [VAL_W-1:0] set_values[$];
        bit                      set_overflow;
        t_sorted_result          owed_q[$];
        int                      errors;

        // Inserts an accepted value; a last request releases the whole sorted set.
        function void note_request(logic signed [VAL_W-1:0] value, logic last);
            int             pos;
            t_sorted_result res;
            if (set_values.size() >= CAPACITY) begin
                set_overflow = 1'b1;
            end else begin
                // Entries strictly greater move up, so equal values keep arrival order.
                pos = set_values.size();
                while (pos > 0 && set_values[pos-1] > value) pos--;
                set_values.insert(pos, value);
            end
            if (last) begin
                foreach (set_values[k]) begin
                    res.value       = set_values[k];
                    res.run_last    = (k == set_values.size() - 1);
                    res.dropped_any = set_overflow;
                    owed_q.push_back(res);
                end
                set_values.delete();
                set_overflow = 1'b0;
            end
        endfunction

        // Compares one result from the block with the oldest one owed.
        function void check_result(logic signed [VAL_W-1:0] value, logic run_last,
                                   logic dropped_any);
            t_sorted_result exp_res;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result: value %0d run_last %b dropped_any %b",
                         $time, value, run_last, dropped_any);
                errors++;
                return;
            end
            exp_res = owed_q.pop_front();
            if (value !== exp_res.value) begin
                $display("%0t: sorted_value expected %0d got %0d",
                         $time, exp_res.value, value);
                errors++;
            end
            if (run_last !== exp_res.run_last) begin
                $display("%0t: run_last expected %b got %b",
                         $time, exp_res.run_last, run_last);
                errors++;
            end
            if (dropped_any !== exp_res.dropped_any) begin
                $display("%0t: dropped_any expected %b got %b",
                         $time, exp_res.dropped_any, dropped_any);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    isort_in_if  in_ch();
    isort_out_if out_ch();

    insertion_sorter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    sort_scoreboard sb = new();
    int             results_seen = 0;
    int             idle_cycles = 0;
    bit             tight_set = 1'b0;
    int             random_sent;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Gap lengths: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value(t_fill_mode mode);
        case (mode)
            FILL_NARROW: return int'($urandom_range(0, 16)) - 8;
            FILL_EDGES: begin
                case ($urandom_range(0, 5))
                    0: return VMIN;
                    1: return VMAX;
                    2: return 0;
                    3: return -1;
                    4: return 1;
                    default: return $urandom;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Offers one request after an optional gap and waits until it is taken.
    task automatic send_value(logic signed [VAL_W-1:0] value, logic last);
        int gap;
        gap = tight_set ? 0 : gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_value <= value;
        in_ch.is_last      <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_set(int count, t_fill_mode mode);
        tight_set = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < count; k++) begin
            send_value(pick_value(mode), k == count - 1);
        end
        random_sent += count;
    endtask

    // Mostly small sets; some fill the store exactly and some overrun it.
    function automatic int pick_set_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return $urandom_range(1, 6);
        if (r < 85) return $urandom_range(7, CAPACITY - 1);
        if (r < 93) return CAPACITY;
        return $urandom_range(CAPACITY + 1, CAPACITY + 4);
    endfunction

    // Output side: random stalls, free-running stretches and one long hold mid-drain.
    initial begin : receiver
        int stall_left;
        int free_left;
        bit long_done;
        stall_left = 0;
        free_left = 0;
        long_done = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!long_done && results_seen >= HOLD_AFTER) begin
                long_done = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (free_left > 0) begin
                    free_left--;
                end else if ($urandom_range(0, 19) == 0) begin
                    free_left = $urandom_range(20, 60);
                end else begin
                    stall_left = gap_len();
                end
            end
        end
    end

    // Watches both channels at each rising edge and counts cycles with no transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result(out_ch.sorted_value, out_ch.run_last, out_ch.dropped_any);
                results_seen++;
            end
            if (in_ch.valid && in_ch.ready) begin
                sb.note_request(in_ch.sample_value, in_ch.is_last);
            end
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    // Ends a run that has stopped moving.
    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        in_ch.valid = 1'b0;
        in_ch.sample_value = '0;
        in_ch.is_last = 1'b0;
        i_rst_n = 1'b0;
        random_sent = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sets of one value at each extreme.
        send_value(VMIN, 1'b1);
        send_value(VMAX, 1'b1);
        // Extremes with repeated values.
        send_value(VMAX, 1'b0);
        send_value(VMIN, 1'b0);
        send_value(0, 1'b0);
        send_value(-1, 1'b0);
        send_value(1, 1'b0);
        send_value(VMIN, 1'b0);
        send_value(VMAX, 1'b1);
        // Already ascending, then fully descending.
        for (int v = -2; v <= 2; v++) send_value(v, v == 2);
        for (int v = 2; v >= -2; v--) send_value(v, v == -2);

        // An overrun set, then a set that fills the store exactly.
        send_set(CAPACITY + 2, FILL_WIDE);
        send_set(CAPACITY, FILL_EDGES);
        while (random_sent < RANDOM_ITEMS) begin
            send_set(pick_set_size(), t_fill_mode'($urandom_range(0, 2)));
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
